// ===== hw/rtl/polar_beam_index_from_point_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the polar beam index unit
// Immediate-consequence and next-cycle implication checks on clock and reset.
// ----------------------------------------------------------------------------
`ifndef POLAR_BEAM_INDEX_FROM_POINT_UNIT_ASSERT_SVH
`define POLAR_BEAM_INDEX_FROM_POINT_UNIT_ASSERT_SVH
`ifndef SYNTH
`define PBI_ASSERT_IMPLIES(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("pbi: implication check failed");
`define PBI_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("pbi: next-cycle check failed");
`else
`define PBI_ASSERT_IMPLIES(label, pre, post)
`define PBI_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== hw/rtl/pbi_pkg.sv =====
// ----------------------------------------------------------------------------
// Polar beam index package
// Word types, register indexes, datapath widths, stage numbering and the
// CORDIC arctangent constants.
// ----------------------------------------------------------------------------
package pbi_pkg;

   localparam int MAX_BEAMS    = 4096;
   localparam int CORDIC_STEPS = 16;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_POSE_COS        = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POSE_SIN        = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_POSE_TX         = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_POSE_TY         = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHI_MIN         = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGULAR_RES     = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGULAR_RES_INV = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_BEAM_COUNT      = 4'd7;

   localparam int MUL_W  = 48;
   localparam int CW     = 51;
   localparam int ANG_W  = 20;
   localparam int DIFF_W = ANG_W + 1;
   localparam int LOW_W  = ANG_W + 2;
   localparam int UP_W   = 32;
   localparam int NRES_W = 30;
   localparam int PROD_W = DIFF_W + 25;
   localparam int IDX_W  = PROD_W - 28;

   localparam logic signed [ANG_W-1:0]  PI_Q16     = 20'sd205887;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd134217728);

   localparam int ST_MUL     = 0;
   localparam int ST_SUM     = 1;
   localparam int ST_ROT     = 2;
   localparam int ST_CORDIC  = 3;
   localparam int ST_CMP     = ST_CORDIC + CORDIC_STEPS;
   localparam int ST_SCALE   = ST_CMP + 1;
   localparam int ST_OUT     = ST_SCALE + 1;
   localparam int NUM_STAGES = ST_OUT + 1;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
   } pbi_req_type;

   typedef struct packed {
      logic [11:0] beam_index;
      logic        out_of_view;
   } pbi_rsp_type;

   function automatic logic signed [ANG_W-1:0] atan_q16(input logic [4:0] step);
      logic signed [ANG_W-1:0] val;
      case (step)
         5'd0:    val = 20'sd51472;
         5'd1:    val = 20'sd30386;
         5'd2:    val = 20'sd16055;
         5'd3:    val = 20'sd8150;
         5'd4:    val = 20'sd4091;
         5'd5:    val = 20'sd2047;
         5'd6:    val = 20'sd1024;
         5'd7:    val = 20'sd512;
         5'd8:    val = 20'sd256;
         5'd9:    val = 20'sd128;
         5'd10:   val = 20'sd64;
         5'd11:   val = 20'sd32;
         5'd12:   val = 20'sd16;
         5'd13:   val = 20'sd8;
         5'd14:   val = 20'sd4;
         5'd15:   val = 20'sd2;
         5'd16:   val = 20'sd1;
         default: val = 20'sd0;
      endcase
      return val;
   endfunction

endpackage

// ===== hw/rtl/polar_beam_index_from_point_unit.sv =====
// ----------------------------------------------------------------------------
// Polar beam index from point unit
// Transforms a Q16.16 point by the inverse sensor pose, takes its angle with
// a pipelined CORDIC and maps the angle to a beam index or an out-of-view flag.
//
//   Channel  Direction  Handshake             Word
//   req      in         req_valid/req_ready   pbi_req_type (point_x, point_y)
//   rsp      out        rsp_valid/rsp_ready   pbi_rsp_type (beam_index, out_of_view)
//   csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// One word enters per cycle while the output drains and no register write is
// pending; the CORDIC runs one iteration per pipeline stage.
// Reset loads the register defaults and empties the pipeline; no clearing pass.
// A stage holds while the next stage is full and not moving, so bubbles close
// up and input is taken while a result waits. Input is held off during a
// register write.
// ----------------------------------------------------------------------------
`include "polar_beam_index_from_point_unit_assert.svh"

module polar_beam_index_from_point_unit
   import pbi_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pbi_req_type            req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pbi_rsp_type            rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic signed [15:0] pose_cos_ff, pose_sin_ff;
   logic signed [31:0] pose_tx_ff, pose_ty_ff;
   logic signed [18:0] phi_min_ff;
   logic [16:0]        angular_res_ff;
   logic [23:0]        angular_res_inv_ff;
   logic [12:0]        beam_count_ff;

   logic [12:0]              n_clamp_in, n_clamp_ff;
   logic [NRES_W-1:0]        nres_in, nres_ff;
   logic signed [UP_W-1:0]   upper_in, upper_ff;
   logic signed [LOW_W-1:0]  lower2_in, lower2_ff;

   logic [NUM_STAGES-1:0] stage_en;
   logic [NUM_STAGES-1:0] valid_in, valid_ff;

   logic signed [MUL_W-1:0] mul_cx_in, mul_sy_in, mul_sx_in, mul_cy_in;
   logic signed [MUL_W-1:0] mul_cx_ff, mul_sy_ff, mul_sx_ff, mul_cy_ff;
   logic signed [CW-1:0]    sum_x_in, sum_y_in, sum_x_ff, sum_y_ff;

   logic signed [CW-1:0]    cx_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0]    cy_ff [CORDIC_STEPS+1];
   logic signed [ANG_W-1:0] cz_ff [CORDIC_STEPS+1];
   logic                    czero_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0]    rot_x_in, rot_y_in;
   logic signed [ANG_W-1:0] rot_z_in;
   logic                    rot_zero_in;

   logic signed [ANG_W-1:0]  ang_sel;
   logic signed [DIFF_W-1:0] diff_in, diff_ff;
   logic                     oov_a_in, oov_a_ff, oov_b_ff;
   logic signed [PROD_W-1:0] prod_in, prod_ff, rnd_sum;
   logic signed [IDX_W-1:0]  idx_full, idx_clip;
   pbi_rsp_type              rsp_in, rsp_ff;

   // Register file.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pose_cos_ff        <= 16'sd16384;
         pose_sin_ff        <= 16'sd0;
         pose_tx_ff         <= 32'sd0;
         pose_ty_ff         <= 32'sd0;
         phi_min_ff         <= 19'sd0;
         angular_res_ff     <= 17'd286;
         angular_res_inv_ff <= 24'd938734;
         beam_count_ff      <= 13'd1440;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_POSE_COS:        pose_cos_ff        <= signed'(csr_data[15:0]);
            CSR_POSE_SIN:        pose_sin_ff        <= signed'(csr_data[15:0]);
            CSR_POSE_TX:         pose_tx_ff         <= signed'(csr_data[31:0]);
            CSR_POSE_TY:         pose_ty_ff         <= signed'(csr_data[31:0]);
            CSR_PHI_MIN:         phi_min_ff         <= signed'(csr_data[18:0]);
            CSR_ANGULAR_RES:     angular_res_ff     <= csr_data[16:0];
            CSR_ANGULAR_RES_INV: angular_res_inv_ff <= csr_data[23:0];
            CSR_BEAM_COUNT:      beam_count_ff      <= csr_data[12:0];
            default: begin
            end
         endcase
      end
   end

   // Field-of-view bounds derived from the registers.
   always_comb begin
      if (32'(beam_count_ff) > 32'(MAX_BEAMS)) begin
         n_clamp_in = 13'(MAX_BEAMS);
      end else begin
         n_clamp_in = beam_count_ff;
      end
      nres_in   = NRES_W'(n_clamp_ff) * NRES_W'(angular_res_ff);
      upper_in  = UP_W'(phi_min_ff) + UP_W'(signed'({1'b0, nres_ff}));
      lower2_in = LOW_W'(signed'({phi_min_ff, 1'b0}))
                  - LOW_W'(signed'({1'b0, angular_res_ff}));
   end

   always_ff @(posedge clock) begin
      n_clamp_ff <= n_clamp_in;
      nres_ff    <= nres_in;
      upper_ff   <= upper_in;
      lower2_ff  <= lower2_in;
   end

   // Pipeline flow control.
   generate
      for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_en
         assign stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   endgenerate
   assign stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;

   assign req_ready = stage_en[ST_MUL] && !csr_valid;

   always_comb begin
      valid_in[0] = req_valid && req_ready;
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // Pose rotation products, then sums with translation.
   always_comb begin
      mul_cx_in = MUL_W'(pose_cos_ff) * MUL_W'(req_data.point_x);
      mul_sy_in = MUL_W'(pose_sin_ff) * MUL_W'(req_data.point_y);
      mul_sx_in = MUL_W'(pose_sin_ff) * MUL_W'(req_data.point_x);
      mul_cy_in = MUL_W'(pose_cos_ff) * MUL_W'(req_data.point_y);
      sum_x_in  = CW'(mul_cx_ff) - CW'(mul_sy_ff) + CW'(signed'({pose_tx_ff, 14'd0}));
      sum_y_in  = CW'(mul_sx_ff) + CW'(mul_cy_ff) + CW'(signed'({pose_ty_ff, 14'd0}));
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_MUL]) begin
         mul_cx_ff <= mul_cx_in;
         mul_sy_ff <= mul_sy_in;
         mul_sx_ff <= mul_sx_in;
         mul_cy_ff <= mul_cy_in;
      end
      if (stage_en[ST_SUM]) begin
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
      end
   end

   // Left half-plane vectors are turned by pi before the CORDIC steps.
   always_comb begin
      rot_zero_in = (sum_x_ff == '0) && (sum_y_ff == '0);
      if (sum_x_ff[CW-1]) begin
         rot_x_in = -sum_x_ff;
         rot_y_in = -sum_y_ff;
         rot_z_in = sum_y_ff[CW-1] ? -PI_Q16 : PI_Q16;
      end else begin
         rot_x_in = sum_x_ff;
         rot_y_in = sum_y_ff;
         rot_z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_ROT]) begin
         cx_ff[0]    <= rot_x_in;
         cy_ff[0]    <= rot_y_in;
         cz_ff[0]    <= rot_z_in;
         czero_ff[0] <= rot_zero_in;
      end
   end

   generate
      for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cstep
         logic signed [CW-1:0]    xs, ys, x_in, y_in;
         logic signed [ANG_W-1:0] z_in;

         always_comb begin
            xs = cx_ff[i] >>> i;
            ys = cy_ff[i] >>> i;
            if (!cy_ff[i][CW-1]) begin
               x_in = cx_ff[i] + ys;
               y_in = cy_ff[i] - xs;
               z_in = cz_ff[i] + atan_q16(5'(i));
            end else begin
               x_in = cx_ff[i] - ys;
               y_in = cy_ff[i] + xs;
               z_in = cz_ff[i] - atan_q16(5'(i));
            end
         end

         always_ff @(posedge clock) begin
            if (stage_en[ST_CORDIC+i]) begin
               cx_ff[i+1]    <= x_in;
               cy_ff[i+1]    <= y_in;
               cz_ff[i+1]    <= z_in;
               czero_ff[i+1] <= czero_ff[i];
            end
         end
      end
   endgenerate

   // Field-of-view test, scaling by the reciprocal step, rounding.
   always_comb begin
      ang_sel  = czero_ff[CORDIC_STEPS] ? '0 : cz_ff[CORDIC_STEPS];
      oov_a_in = (LOW_W'(signed'({ang_sel, 1'b0})) <= lower2_ff)
                 || (UP_W'(ang_sel) >= upper_ff);
      diff_in  = DIFF_W'(ang_sel) - DIFF_W'(phi_min_ff);
      prod_in  = PROD_W'(diff_ff) * PROD_W'(signed'({1'b0, angular_res_inv_ff}));
      rnd_sum  = prod_ff + ROUND_HALF;
      idx_full = rnd_sum[PROD_W-1:28];
      idx_clip = idx_full[IDX_W-1] ? '0 : idx_full;
      if (oov_b_ff || (idx_clip >= IDX_W'(signed'({1'b0, n_clamp_ff})))) begin
         rsp_in.out_of_view = 1'b1;
         rsp_in.beam_index  = '0;
      end else begin
         rsp_in.out_of_view = 1'b0;
         rsp_in.beam_index  = idx_clip[11:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_CMP]) begin
         diff_ff  <= diff_in;
         oov_a_ff <= oov_a_in;
      end
      if (stage_en[ST_SCALE]) begin
         prod_ff  <= prod_in;
         oov_b_ff <= oov_a_ff;
      end
      if (stage_en[ST_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff[ST_OUT];
   assign rsp_data  = rsp_ff;

   `PBI_ASSERT_NEXT(a_accept_fills_first_stage, req_valid && req_ready, valid_ff[ST_MUL])
   `PBI_ASSERT_NEXT(a_held_stage_keeps_word, valid_ff[ST_SUM] && !stage_en[ST_SUM], valid_ff[ST_SUM])
   `PBI_ASSERT_IMPLIES(a_oov_has_zero_index, rsp_valid && rsp_data.out_of_view, rsp_data.beam_index == '0)
   `PBI_ASSERT_IMPLIES(a_index_below_count, rsp_valid && !rsp_data.out_of_view, 13'(rsp_data.beam_index) < n_clamp_ff)

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the polar beam index from point unit
// Streams points through the unit under a series of pose and beam settings,
// predicts each beam index and out-of-view flag from the configured pose, an
// integer CORDIC arctangent and the field-of-view bounds, and checks every
// result word in order, with random stalls on both channels in the first eight phases.
// ----------------------------------------------------------------------------
module tb_top
   import pbi_pkg::*;
();

   localparam int HALF_TURN = 205887;
   localparam int PHASES = 12;
   localparam int RANDOM_PER_PHASE = 36;
   localparam int SETTLE_CYCLES = 2 * (CORDIC_STEPS + 6);
   localparam int TIME_LIMIT = 2000000;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_FIRST = 4'd8;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LAST  = 4'd15;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   pbi_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   pbi_rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   logic signed [15:0] cfg_cos = 16'sd16384;
   logic signed [15:0] cfg_sin = 16'sd0;
   logic signed [31:0] cfg_tx = 32'sd0;
   logic signed [31:0] cfg_ty = 32'sd0;
   logic signed [18:0] cfg_phi_min = 19'sd0;
   logic [16:0] cfg_res = 17'd286;
   logic [23:0] cfg_res_inv = 24'd938734;
   logic [12:0] cfg_beams = 13'd1440;

   pbi_req_type points_to_send[$];
   pbi_rsp_type beams_expected[$];
   logic point_taken = 1'b0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatch_count = 0;
   int points_accepted = 0;
   int results_in_view = 0;
   int results_out_of_view = 0;
   int settings_loaded = 1;

   polar_beam_index_from_point_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(TIME_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   function automatic pbi_rsp_type predict_beam(input pbi_req_type pt);
      pbi_rsp_type beam;
      longint rx, ry, xs, ys, angle, phi, res, inv, beams, upper, index;
      int step;
      rx = longint'(cfg_cos) * longint'(pt.point_x) - longint'(cfg_sin) * longint'(pt.point_y)
           + longint'(cfg_tx) * 16384;
      ry = longint'(cfg_sin) * longint'(pt.point_x) + longint'(cfg_cos) * longint'(pt.point_y)
           + longint'(cfg_ty) * 16384;
      angle = 0;
      if (rx != 0 || ry != 0) begin
         if (rx < 0) begin
            angle = (ry >= 0) ? longint'(HALF_TURN) : -longint'(HALF_TURN);
            rx = -rx;
            ry = -ry;
         end
         for (step = 0; step < CORDIC_STEPS; step++) begin
            xs = rx >>> step;
            ys = ry >>> step;
            if (ry >= 0) begin
               rx = rx + ys;
               ry = ry - xs;
               angle += longint'($rtoi($atan(2.0 ** (-step)) * 65536.0 + 0.5));
            end else begin
               rx = rx - ys;
               ry = ry + xs;
               angle -= longint'($rtoi($atan(2.0 ** (-step)) * 65536.0 + 0.5));
            end
         end
      end
      phi = longint'(cfg_phi_min);
      res = longint'(cfg_res);
      inv = longint'(cfg_res_inv);
      beams = (cfg_beams > MAX_BEAMS) ? longint'(MAX_BEAMS) : longint'(cfg_beams);
      upper = phi + beams * res;
      index = 0;
      beam.out_of_view = 1'b0;
      if (2 * angle <= 2 * phi - res || angle >= upper) begin
         beam.out_of_view = 1'b1;
      end else begin
         index = ((angle - phi) * inv + (longint'(1) <<< 27)) >>> 28;
         if (index < 0) index = 0;
         if (index >= beams) begin
            beam.out_of_view = 1'b1;
            index = 0;
         end
      end
      beam.beam_index = index[11:0];
      return beam;
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] value);
      case (idx)
         CSR_POSE_COS:        cfg_cos = value[15:0];
         CSR_POSE_SIN:        cfg_sin = value[15:0];
         CSR_POSE_TX:         cfg_tx = value;
         CSR_POSE_TY:         cfg_ty = value;
         CSR_PHI_MIN:         cfg_phi_min = value[18:0];
         CSR_ANGULAR_RES:     cfg_res = value[16:0];
         CSR_ANGULAR_RES_INV: cfg_res_inv = value[23:0];
         CSR_BEAM_COUNT:      cfg_beams = value[12:0];
         default: ;
      endcase
   endfunction

   function automatic pbi_req_type random_point();
      pbi_req_type pt;
      logic signed [31:0] noise;
      pt.point_x = $urandom;
      pt.point_y = $urandom;
      noise = $urandom;
      case ($urandom_range(3, 0))
         0: ;
         1: begin
            pt.point_x = pt.point_x >>> $urandom_range(30, 6);
            pt.point_y = pt.point_y >>> $urandom_range(30, 6);
         end
         2: begin
            pt.point_x = 32'h1 << $urandom_range(30, 16);
            pt.point_y = noise >>> $urandom_range(31, 10);
         end
         default: begin
            pt.point_x = pt.point_x >>> 26;
            pt.point_y = pt.point_y >>> 26;
         end
      endcase
      return pt;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic queue_point(input logic signed [31:0] x, input logic signed [31:0] y);
      pbi_req_type pt;
      pt.point_x = x;
      pt.point_y = y;
      points_to_send.push_back(pt);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, value);
   endtask

   task automatic load_config(input logic [31:0] cos_v, input logic [31:0] sin_v,
                              input logic [31:0] tx_v, input logic [31:0] ty_v,
                              input logic [31:0] phi_v, input logic [31:0] res_v,
                              input logic [31:0] inv_v, input logic [31:0] beams_v);
      csr_write(CSR_INDEX_W'($urandom_range(CSR_SPARE_LAST, CSR_SPARE_FIRST)), $urandom);
      csr_write(CSR_POSE_COS, cos_v);
      csr_write(CSR_POSE_SIN, sin_v);
      csr_write(CSR_POSE_TX, tx_v);
      csr_write(CSR_POSE_TY, ty_v);
      csr_write(CSR_PHI_MIN, phi_v);
      csr_write(CSR_ANGULAR_RES, res_v);
      csr_write(CSR_ANGULAR_RES_INV, inv_v);
      csr_write(CSR_BEAM_COUNT, beams_v);
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   task automatic drain();
      do @(posedge clock);
      while (points_to_send.size() != 0 || req_valid || beams_expected.size() != 0);
   endtask

   // Driver: a word stays on the bus until the monitor has seen it taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || point_taken) begin
            if (points_to_send.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               req_data <= points_to_send.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : monitor
      pbi_rsp_type want;
      if (reset) begin
         point_taken <= 1'b0;
      end else begin
         point_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            beams_expected.push_back(predict_beam(req_data));
            points_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (beams_expected.size() == 0) begin
               report_mismatch($sformatf("result word with nothing pending: index %0d flag %b",
                                         rsp_data.beam_index, rsp_data.out_of_view));
            end else begin
               want = beams_expected.pop_front();
               if (rsp_data.beam_index !== want.beam_index)
                  report_mismatch($sformatf("beam_index %0d, expected %0d",
                                            rsp_data.beam_index, want.beam_index));
               if (rsp_data.out_of_view !== want.out_of_view)
                  report_mismatch($sformatf("out_of_view %b, expected %b",
                                            rsp_data.out_of_view, want.out_of_view));
               if (want.out_of_view) results_out_of_view++;
               else results_in_view++;
            end
         end
      end
   end

   initial begin : stimulus
      int phase;
      logic [31:0] res_pick;
      logic [31:0] inv_pick;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (phase = 0; phase < PHASES; phase++) begin
         drain();
         if (phase < 4) begin
            send_idle_pct = 9;
            recv_idle_pct = 86;
         end else if (phase < 8) begin
            send_idle_pct = 86;
            recv_idle_pct = 9;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (phase)
            0: begin
               queue_point(32'sh7FFFFFFF, 32'sh7FFFFFFF);
               queue_point(32'sh80000000, 32'sh80000000);
               queue_point(32'sh7FFFFFFF, 32'sh80000000);
               queue_point(32'sh80000000, 32'sh7FFFFFFF);
               queue_point(32'sh7FFFFFFF, 32'sh0);
               queue_point(32'sh80000000, 32'sh0);
               queue_point(32'sh0, 32'sh7FFFFFFF);
               queue_point(32'sh0, 32'sh80000000);
               queue_point(32'sh0, 32'sh0);
               queue_point(32'sh1, 32'sh0);
               queue_point(32'sh0, 32'sh1);
               queue_point(-32'sh1, 32'sh0);
               queue_point(-32'sh1, -32'sh1);
               queue_point(32'sh0, -32'sh1);
               queue_point(-32'sh1, 32'sh1);
            end
            1: load_config(16384, 0, 32'h0001_8000, -32'sh0000_4000, -205887, 286, 938734,
                           1440);
            2: load_config(0, 16384, 5 << 16, -3 << 16, -102943, 572, 469367, 360);
            3: load_config(32'hFFFF8000, 32'h7FFF, 32'h7FFFFFFF, 32'h80000000, 32'h3FFFF,
                           32'h1FFFF, 32'hFFFFFF, 32'h1FFF);
            4: load_config(11585, -11585, 0, 0, 32'hFFFC0000, 286, 938734, 0);
            5: load_config(-16384, -16384, -32'sh10000, 32'sh10000, 0, 0, 938734, 4096);
            6: load_config(16384, 0, 0, 0, -205887, 1, 0, 4096);
            7: begin
               // A step far coarser than the reciprocal claims, so angles just
               // above the lower bound round to an index below zero.
               load_config(16384, 0, 0, 0, 0, 1000, 32'hFFFFFF, 4096);
               queue_point(32'sh40000000, -32'sh00400000);
               queue_point(32'sh40000000, -32'sh00100000);
               queue_point(32'sh40000000, -32'sh00010000);
               queue_point(32'sh40000000, 32'sh00010000);
            end
            default: begin
               res_pick = $urandom_range(2000, 17);
               inv_pick = ((32'd1 << 28) + res_pick / 2) / res_pick;
               if (inv_pick > 32'hFFFFFF) inv_pick = 32'hFFFFFF;
               load_config(int'($urandom_range(32768, 0)) - 16384,
                           int'($urandom_range(32768, 0)) - 16384,
                           int'($urandom) >>> $urandom_range(31, 8),
                           int'($urandom) >>> $urandom_range(31, 8),
                           int'($urandom_range(2 * HALF_TURN, 0)) - HALF_TURN,
                           res_pick, inv_pick, $urandom_range(4096, 1));
            end
         endcase
         repeat (RANDOM_PER_PHASE) points_to_send.push_back(random_point());
      end
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Checked %0d points under %0d register settings, with both channels stalling.",
               points_accepted, settings_loaded);
      $display("Results: %0d inside the field of view, %0d flagged out of view.",
               results_in_view, results_out_of_view);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== polar_beam_index_from_point_unit.f =====
+incdir+hw/rtl
hw/rtl/pbi_pkg.sv
hw/rtl/polar_beam_index_from_point_unit.sv
sim/tb_top.sv
